### rtl/mbde_pkg.sv
`timescale 1ns / 1ps

package mbde_pkg;

    // field widths on the ports
    localparam int BTN_W     = 17;
    localparam int NOW_W     = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // default sizing of the button array and the time base
    localparam int NUM_BUTTONS_DEF = 17;
    localparam int TIME_BITS_DEF   = 32;

    // register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CFG_W-1:0] IGNORE_RST   = 16'd200;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE   = 1'b1;

    // stream packing
    localparam int S_RAW_LSB  = 0;
    localparam int S_NOW_LSB  = S_RAW_LSB + BTN_W;
    localparam int S_USED_W   = S_NOW_LSB + NOW_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

    localparam int M_PRS_LSB  = 0;
    localparam int M_REL_LSB  = M_PRS_LSB + BTN_W;
    localparam int M_DWN_LSB  = M_REL_LSB + BTN_W;
    localparam int M_USED_W   = M_DWN_LSB + BTN_W;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

    // control from the top level to every button lane
    typedef struct packed {
        logic load;     // item leaves the input register this cycle
        logic connect;  // item is a connect event
        logic resync;   // time is before the ignore deadline
    } mbde_ctl_t;

endpackage

### rtl/mbde_in_stage.sv
`timescale 1ns / 1ps

module mbde_in_stage #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         valid_reg;
    logic [W-1:0] data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

endmodule

### rtl/mbde_button.sv
`timescale 1ns / 1ps

module mbde_button #(
    parameter int TIME_BITS = mbde_pkg::TIME_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mbde_pkg::mbde_ctl_t        ctl,
    input  logic                       raw_bit,
    input  logic [TIME_BITS-1:0]       now,
    input  logic [mbde_pkg::CFG_W-1:0] debounce,
    output logic                       pressed,
    output logic                       released,
    output logic                       level_next
);

    logic                 level_reg;
    logic [TIME_BITS-1:0] stamp_reg;
    logic [TIME_BITS-1:0] stamp_next;
    logic [TIME_BITS-1:0] dt;
    logic                 flip;

    always_comb begin
        // wrapping age of the last accepted change
        dt   = now - stamp_reg;
        flip = !ctl.connect && !ctl.resync && (raw_bit != level_reg)
               && (dt > TIME_BITS'(debounce));

        level_next = (ctl.connect || ctl.resync || flip) ? raw_bit : level_reg;

        if (ctl.resync || flip) begin
            stamp_next = now;
        end else if (ctl.connect) begin
            stamp_next = '0;
        end else begin
            stamp_next = stamp_reg;
        end

        pressed  = flip && raw_bit;
        released = flip && !raw_bit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 1'b0;
            stamp_reg <= '0;
        end else if (ctl.load) begin
            level_reg <= level_next;
            stamp_reg <= stamp_next;
        end
    end

endmodule

### rtl/multi_button_debounce_events.sv
`timescale 1ns / 1ps
// path: an accepted request is held in the input register, then its result in the result register
// throughput: one request per cycle while the sink takes results or the result register is empty
// each item's work is one subtract and compare per button
// s_tready follows m_tready combinationally, so a full pipe still moves when the sink takes a result
// reset (aresetn low, synchronous): pipe empty, levels and stamps zero, not connected, deadline zero
// registers return to debounce_ms 50 and ignore_window_ms 200

module multi_button_debounce_events #(
    parameter int NUM_BUTTONS = mbde_pkg::NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = mbde_pkg::TIME_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [mbde_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbde_pkg::CFG_W-1:0]     cfg_wdata,

    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mbde_pkg::S_TDATA_W-1:0] s_tdata,  // raw_buttons, now_ms, zero pad
    input  logic [0:0]                     s_tuser,  // func (0 poll, 1 connect)

    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mbde_pkg::M_TDATA_W-1:0] m_tdata   // pressed_events, released_events,
                                                     // down_levels, zero pad
);

    localparam int BTN_W = mbde_pkg::BTN_W;
    localparam int NOW_W = mbde_pkg::NOW_W;
    localparam int CFG_W = mbde_pkg::CFG_W;
    localparam int PAY_W = 1 + NUM_BUTTONS + TIME_BITS;

    // configuration registers
    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= mbde_pkg::DEBOUNCE_RST;
            window_reg   <= mbde_pkg::IGNORE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mbde_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_wdata;
                mbde_pkg::CFG_IGNORE:   window_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // fit the port fields to the internal button count and time base
    logic [BTN_W-1:0]       s_raw_field;
    logic [NOW_W-1:0]       s_now_field;
    logic [NUM_BUTTONS-1:0] s_raw;
    logic [TIME_BITS-1:0]   s_now;

    assign s_raw_field = s_tdata[mbde_pkg::S_RAW_LSB +: BTN_W];
    assign s_now_field = s_tdata[mbde_pkg::S_NOW_LSB +: NOW_W];

    // buttons beyond the field see a released level
    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_raw
        if (i < BTN_W) begin : g_in
            assign s_raw[i] = s_raw_field[i];
        end else begin : g_zero
            assign s_raw[i] = 1'b0;
        end
    end

    // time is kept modulo 2^TIME_BITS
    if (TIME_BITS >= NOW_W) begin : g_now_ext
        assign s_now = TIME_BITS'(s_now_field);
    end else begin : g_now_trunc
        assign s_now = s_now_field[TIME_BITS-1:0];
    end

    // input register
    logic                   st_valid;
    logic [PAY_W-1:0]       st_data;
    logic                   advance;
    logic                   st_func;
    logic [NUM_BUTTONS-1:0] st_raw;
    logic [TIME_BITS-1:0]   st_now;

    mbde_in_stage #(
        .W (PAY_W)
    ) u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   ({s_now, s_raw, s_tuser[0]}),
        .out_valid (st_valid),
        .out_ready (advance),
        .out_data  (st_data)
    );

    assign st_func = st_data[0];
    assign st_raw  = st_data[1 +: NUM_BUTTONS];
    assign st_now  = st_data[1 + NUM_BUTTONS +: TIME_BITS];

    // connection state and ignore deadline
    logic                   connected_reg;
    logic [TIME_BITS-1:0]   deadline_reg;
    logic [TIME_BITS-1:0]   deadline_new;
    logic [TIME_BITS-1:0]   deadline_eff;
    logic [NUM_BUTTONS-1:0] raw_eff;
    mbde_pkg::mbde_ctl_t    ctl;

    always_comb begin
        // the result register frees up when empty or when its result is taken
        advance      = !m_tvalid || m_tready;
        deadline_new = st_now + TIME_BITS'(window_reg);
        // a connect compares against the deadline it sets itself
        deadline_eff = st_func ? deadline_new : deadline_reg;
        // raw levels read as released until the first connect
        raw_eff      = (st_func || connected_reg) ? st_raw : '0;
        ctl.load     = st_valid && advance;
        ctl.connect  = st_func;
        ctl.resync   = st_now < deadline_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            connected_reg <= 1'b0;
            deadline_reg  <= '0;
        end else if (ctl.load && st_func) begin
            connected_reg <= 1'b1;
            deadline_reg  <= deadline_new;
        end
    end

    // one lane per button: debounced level and change stamp
    logic [NUM_BUTTONS-1:0] pressed;
    logic [NUM_BUTTONS-1:0] released;
    logic [NUM_BUTTONS-1:0] level_next;

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
        mbde_button #(
            .TIME_BITS (TIME_BITS)
        ) u_button (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .raw_bit    (raw_eff[i]),
            .now        (st_now),
            .debounce   (debounce_reg),
            .pressed    (pressed[i]),
            .released   (released[i]),
            .level_next (level_next[i])
        );
    end

    // fit the lane vectors back to the field width; bits without a button read zero
    logic [BTN_W-1:0] prs_field;
    logic [BTN_W-1:0] rel_field;
    logic [BTN_W-1:0] dwn_field;

    for (genvar j = 0; j < BTN_W; j++) begin : g_out
        if (j < NUM_BUTTONS) begin : g_btn_bit
            assign prs_field[j] = pressed[j];
            assign rel_field[j] = released[j];
            assign dwn_field[j] = level_next[j];
        end else begin : g_zero_bit
            assign prs_field[j] = 1'b0;
            assign rel_field[j] = 1'b0;
            assign dwn_field[j] = 1'b0;
        end
    end

    // result register
    logic                           m_valid_reg;
    logic [mbde_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [mbde_pkg::M_TDATA_W-1:0] m_data_next;

    always_comb begin
        m_data_next = '0;
        m_data_next[mbde_pkg::M_PRS_LSB +: BTN_W] = prs_field;
        m_data_next[mbde_pkg::M_REL_LSB +: BTN_W] = rel_field;
        m_data_next[mbde_pkg::M_DWN_LSB +: BTN_W] = dwn_field;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= st_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### rtl/mbde_checker.sv
`timescale 1ns / 1ps

module mbde_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mbde_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int BTN_W = mbde_pkg::BTN_W;

    logic [BTN_W-1:0] prs;
    logic [BTN_W-1:0] rel;
    logic [BTN_W-1:0] dwn;

    assign prs = m_tdata[mbde_pkg::M_PRS_LSB +: BTN_W];
    assign rel = m_tdata[mbde_pkg::M_REL_LSB +: BTN_W];
    assign dwn = m_tdata[mbde_pkg::M_DWN_LSB +: BTN_W];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a button cannot both press and release in one item
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (prs & rel) == '0)
        else $error("press and release on the same button");

    // a press leaves the button held
    a_press_down: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (prs & ~dwn) == '0)
        else $error("press reported on a button that is not held");

    // a release leaves the button up
    a_rel_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (rel & dwn) == '0)
        else $error("release reported on a button that is still held");

endmodule

bind multi_button_debounce_events mbde_checker u_mbde_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
